FILE: rtl/knight_move_warnsdorff_ranker_core_assert.svh
// Assertion macros for the knight move ranker core.
// Included by the top level; has no other dependencies.
`ifndef KNIGHT_MOVE_WARNSDORFF_RANKER_CORE_ASSERT_SVH
`define KNIGHT_MOVE_WARNSDORFF_RANKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define KMWR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmwr: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define KMWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmwr: next-cycle check failed");
`else
`define KMWR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define KMWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/kmwr_pkg.sv
// Shared types, codes and the knight jump table for the knight move ranker.
// No dependencies; the core, the jump unit and the rank list import this package.
package kmwr_pkg;

    localparam int POS_W        = 4;
    localparam int SIDE_CFG_W   = 5;
    localparam int TXW          = 7;
    localparam int MAX_MOVES    = 8;
    localparam int IDX_W        = 3;
    localparam int N_W          = 4;

    localparam logic [SIDE_CFG_W-1:0] BOARD_SIDE_RST = 5'd8;

    typedef logic [1:0]            t_status;
    typedef logic signed [TXW-1:0] t_coord;

    localparam t_status ST_FREE    = 2'd0;
    localparam t_status ST_START   = 2'd1;
    localparam t_status ST_VISITED = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Jump order: (+1,+2) (+2,+1) (+2,-1) (+1,-2) (-1,-2) (-2,-1) (-2,+1) (-1,+2).
    localparam t_coord JUMP_DX [MAX_MOVES] = '{7'sd1, 7'sd2, 7'sd2, 7'sd1,
                                               -7'sd1, -7'sd2, -7'sd2, -7'sd1};
    localparam t_coord JUMP_DY [MAX_MOVES] = '{7'sd2, 7'sd1, -7'sd1, -7'sd2,
                                               -7'sd2, -7'sd1, 7'sd1, 7'sd2};

    typedef struct packed {
        logic                func;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        t_status             cell_status;
        logic                offer_start;
    } t_cmd;

    typedef struct packed {
        logic                cand_valid;
        logic [POS_W-1:0]    cand_x;
        logic [POS_W-1:0]    cand_y;
        logic [N_W-1:0]      onward_count;
        logic                last;
    } t_res;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [N_W-1:0]   count;
    } t_rank_entry;

    // A target qualifies when it is free, or is the start cell and the start is offered.
    function automatic logic status_ok(input t_status st, input logic offer);
        return (st == ST_FREE) || (offer && (st == ST_START));
    endfunction

endpackage

FILE: rtl/knight_move_warnsdorff_ranker_core.sv
// A write item is handled in S_IDLE. A query steps through S_OUT_RD and S_OUT_EV for
// each knight jump and stays in S_IN for the inner walk of each candidate, then shows
// its results on consecutive cycles; with no candidate it shows one invalid result.
// Throughput: one query at a time, set by the single cell store read port.
// Reset (synchronous, active low) sets board_side to 8 and then sweeps the cell store
// to all free, with busy high. Results cannot be stalled.
module knight_move_warnsdorff_ranker_core #(
    parameter int MAX_SIDE = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  kmwr_pkg::t_cmd                      i_cmd,
    input  logic                                i_cfg_we,
    input  logic [kmwr_pkg::SIDE_CFG_W-1:0]     i_cfg_wdata,
    output logic                                o_res_strobe,
    output kmwr_pkg::t_res                      o_res
);
    import kmwr_pkg::*;

`include "knight_move_warnsdorff_ranker_core_assert.svh"

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(MAX_SIDE + 1);

    // Sequencer states. Each query walks the eight jumps from the position; every
    // qualifying target is probed in turn with its own eight jumps, the hits are
    // counted, and the candidate is inserted into the sorted list.
    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_OUT_RD = 6'b000100,
        S_OUT_EV = 6'b001000,
        S_IN     = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state                  r_state,      n_state;
    logic [SIDE_CFG_W-1:0]   r_board_side;
    logic [AW-1:0]           r_clr,        n_clr;
    t_point                  r_pos,        n_pos;
    logic                    r_offer,      n_offer;
    logic [IDX_W-1:0]        r_k,          n_k;
    logic [N_W-1:0]          r_j,          n_j;
    t_point                  r_cand,       n_cand;
    t_point                  r_tgt,        n_tgt;
    logic [N_W-1:0]          r_cnt,        n_cnt;
    logic                    r_pend,       n_pend;
    logic                    r_onb,        n_onb;
    logic [IDX_W-1:0]        r_e,          n_e;
    t_res                    r_res,        n_res;
    logic                    r_res_stb,    n_res_stb;

    logic [SW-1:0]           side;
    t_point                  probe_base;
    logic [IDX_W-1:0]        probe_jump;
    t_point                  probe_tgt;
    logic                    probe_onb;
    logic [AW-1:0]           probe_addr;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    t_status                 ram_wdata;
    t_status                 ram_rdata;

    logic                    list_clear;
    logic                    list_insert;
    t_rank_entry             list_entry;
    t_rank_entry             list_rd;
    logic [N_W-1:0]          list_count;

    logic                    inner_hit;
    logic [N_W-1:0]          cnt_sum;
    logic                    in_store;

    // A board side beyond the store saturates to the store side.
    assign side = (int'(r_board_side) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(r_board_side);

    // The jump unit serves the outer walk from the position and the inner walk
    // from the current candidate.
    assign probe_base = (r_state == S_IN) ? r_cand : r_pos;
    assign probe_jump = (r_state == S_IN) ? r_j[IDX_W-1:0] : r_k;

    kmwr_probe #(
        .MAX_SIDE (MAX_SIDE)
    ) u_probe (
        .i_base     (probe_base),
        .i_jump     (probe_jump),
        .i_side     (side),
        .o_tgt      (probe_tgt),
        .o_on_board (probe_onb),
        .o_addr     (probe_addr)
    );

    kmwr_ram #(
        .WIDTH ($bits(t_status)),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (probe_addr),
        .o_rdata (ram_rdata)
    );

    // The inner walk issues one read per cycle; the data of the read issued in the
    // previous cycle is judged in this one, so the count trails the issue.
    assign inner_hit = r_pend && r_onb && status_ok(ram_rdata, r_offer);
    assign cnt_sum   = r_cnt + N_W'(inner_hit);

    always_comb begin
        list_entry.x     = r_cand.x[POS_W-1:0];
        list_entry.y     = r_cand.y[POS_W-1:0];
        list_entry.count = cnt_sum;
    end

    kmwr_rank_list u_list (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (list_clear),
        .i_insert   (list_insert),
        .i_entry    (list_entry),
        .i_rd_idx   (r_e),
        .o_rd_entry (list_rd),
        .o_count    (list_count)
    );

    // Writes at a column or row outside the store are dropped.
    assign in_store = (int'(i_cmd.pos_x) < MAX_SIDE) && (int'(i_cmd.pos_y) < MAX_SIDE);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_pos     = r_pos;
        n_offer   = r_offer;
        n_k       = r_k;
        n_j       = r_j;
        n_cand    = r_cand;
        n_tgt     = r_tgt;
        n_cnt     = r_cnt;
        n_pend    = r_pend;
        n_onb     = r_onb;
        n_e       = r_e;
        n_res     = r_res;
        n_res_stb = 1'b0;

        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = ST_FREE;
        list_clear  = 1'b0;
        list_insert = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end

            S_IDLE: begin
                if (start) begin
                    if (i_cmd.func == FUNC_WRITE) begin
                        ram_we    = in_store;
                        ram_waddr = AW'(i_cmd.pos_y) * AW'(MAX_SIDE) + AW'(i_cmd.pos_x);
                        ram_wdata = i_cmd.cell_status;
                    end else begin
                        n_pos.x    = TXW'(i_cmd.pos_x);
                        n_pos.y    = TXW'(i_cmd.pos_y);
                        n_offer    = i_cmd.offer_start;
                        n_k        = '0;
                        list_clear = 1'b1;
                        n_state    = S_OUT_RD;
                    end
                end
            end

            S_OUT_RD: begin
                n_onb   = probe_onb;
                n_tgt   = probe_tgt;
                n_state = S_OUT_EV;
            end

            S_OUT_EV: begin
                if (r_onb && status_ok(ram_rdata, r_offer)) begin
                    n_cand  = r_tgt;
                    n_j     = '0;
                    n_cnt   = '0;
                    n_pend  = 1'b0;
                    n_state = S_IN;
                end else if (r_k == IDX_W'(MAX_MOVES - 1)) begin
                    n_e     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_k     = r_k + IDX_W'(1);
                    n_state = S_OUT_RD;
                end
            end

            S_IN: begin
                n_cnt = cnt_sum;
                if (r_j == N_W'(MAX_MOVES)) begin
                    // Last read judged: the count is final, place the candidate.
                    list_insert = 1'b1;
                    n_pend      = 1'b0;
                    if (r_k == IDX_W'(MAX_MOVES - 1)) begin
                        n_e     = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = S_OUT_RD;
                    end
                end else begin
                    n_pend = 1'b1;
                    n_onb  = probe_onb;
                    n_j    = r_j + N_W'(1);
                end
            end

            S_EMIT: begin
                n_res_stb = 1'b1;
                if (list_count == '0) begin
                    // No candidate: a single invalid result closes the query.
                    n_res.cand_valid   = 1'b0;
                    n_res.cand_x       = '0;
                    n_res.cand_y       = '0;
                    n_res.onward_count = '0;
                    n_res.last         = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    n_res.cand_valid   = 1'b1;
                    n_res.cand_x       = list_rd.x;
                    n_res.cand_y       = list_rd.y;
                    n_res.onward_count = list_rd.count;
                    n_res.last         = (N_W'(r_e) + N_W'(1)) == list_count;
                    if (n_res.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_e = r_e + IDX_W'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_board_side <= BOARD_SIDE_RST;
            r_clr        <= '0;
            r_k          <= '0;
            r_j          <= '0;
            r_pend       <= 1'b0;
            r_e          <= '0;
            r_res_stb    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_k       <= n_k;
            r_j       <= n_j;
            r_pend    <= n_pend;
            r_e       <= n_e;
            r_res_stb <= n_res_stb;
            if (i_cfg_we) begin
                r_board_side <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_offer <= n_offer;
        r_cand  <= n_cand;
        r_tgt   <= n_tgt;
        r_cnt   <= n_cnt;
        r_onb   <= n_onb;
        r_res   <= n_res;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_res_strobe = r_res_stb;
    assign o_res        = r_res;

    // A result that is not the last one must leave the block still busy.
    `KMWR_ASSERT_SAME(a_more_results_busy, i_clk, i_rst_n, o_res_strobe && !o_res.last, busy)
    // An invalid result is always the only and therefore last one of its query.
    `KMWR_ASSERT_SAME(a_invalid_is_last, i_clk, i_rst_n, o_res_strobe && !o_res.cand_valid, o_res.last)
    // An accepted query occupies the block in the following cycle.
    `KMWR_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, start && !busy && (i_cmd.func == FUNC_QUERY), busy)
    // A cell write leaves the block idle, with no result strobe.
    `KMWR_ASSERT_NEXT(a_write_idle, i_clk, i_rst_n, start && !busy && (i_cmd.func == FUNC_WRITE), !busy && !o_res_strobe)

endmodule

FILE: rtl/kmwr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kmwr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/kmwr_probe.sv
// Shared jump unit: applies one knight jump, checks the board bounds and forms
// the cell address. Depends on kmwr_pkg.
module kmwr_probe #(
    parameter int MAX_SIDE = 16
) (
    input  kmwr_pkg::t_point                        i_base,
    input  logic [kmwr_pkg::IDX_W-1:0]              i_jump,
    input  logic [$clog2(MAX_SIDE+1)-1:0]           i_side,
    output kmwr_pkg::t_point                        o_tgt,
    output logic                                    o_on_board,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]    o_addr
);
    import kmwr_pkg::*;

    localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

    t_point           tgt;
    logic [TXW-1:0]   tx_u;
    logic [TXW-1:0]   ty_u;
    logic             on_board;

    always_comb begin
        tgt.x = i_base.x + JUMP_DX[i_jump];
        tgt.y = i_base.y + JUMP_DY[i_jump];
    end

    assign tx_u = unsigned'(tgt.x);
    assign ty_u = unsigned'(tgt.y);

    assign on_board = !tgt.x[TXW-1] && !tgt.y[TXW-1]
                      && (int'(tx_u) < int'(i_side)) && (int'(ty_u) < int'(i_side));

    // Off-board targets read address zero; the result is discarded anyway.
    assign o_addr = on_board ? (AW'(ty_u) * AW'(MAX_SIDE) + AW'(tx_u)) : '0;
    assign o_tgt      = tgt;
    assign o_on_board = on_board;

endmodule

FILE: rtl/kmwr_rank_list.sv
// Eight-entry candidate list kept sorted by onward count, filled by stable insertion.
// Depends on kmwr_pkg.
module kmwr_rank_list (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_insert,
    input  kmwr_pkg::t_rank_entry          i_entry,
    input  logic [kmwr_pkg::IDX_W-1:0]     i_rd_idx,
    output kmwr_pkg::t_rank_entry          o_rd_entry,
    output logic [kmwr_pkg::N_W-1:0]       o_count
);
    import kmwr_pkg::*;

    t_rank_entry      r_ent [MAX_MOVES];
    t_rank_entry      n_ent [MAX_MOVES];
    logic [N_W-1:0]   r_count;
    logic [MAX_MOVES-1:0] keep;

    // An entry stays in place when it is in use and its count is not greater
    // than the new one; the kept entries form a prefix of the sorted list.
    always_comb begin
        for (int i = 0; i < MAX_MOVES; i++) begin
            keep[i] = (N_W'(i) < r_count) && (r_ent[i].count <= i_entry.count);
        end
        n_ent[0] = keep[0] ? r_ent[0] : i_entry;
        for (int i = 1; i < MAX_MOVES; i++) begin
            if (keep[i]) begin
                n_ent[i] = r_ent[i];
            end else if (keep[i-1]) begin
                n_ent[i] = i_entry;
            end else begin
                n_ent[i] = r_ent[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_clear) begin
            r_count <= '0;
        end else if (i_insert) begin
            r_count <= r_count + N_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_insert) begin
            r_ent <= n_ent;
        end
    end

    assign o_rd_entry = r_ent[i_rd_idx];
    assign o_count    = r_count;

endmodule
